/* rtl/metronome_subdivision_click_sequencer_assert.svh */
// Assertion macros for the click sequencer.
`ifndef METRONOME_SUBDIVISION_CLICK_SEQUENCER_ASSERT_SVH
`define METRONOME_SUBDIVISION_CLICK_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define MSCS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define MSCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MSCS_ASSERT_SAME(label, ante, cons, msg)

`define MSCS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/mscs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mscs_pkg;

   localparam int SpbWidth = 22;
   localparam int BpbWidth = 5;
   localparam int IdxWidth = 13;
   localparam int CsrIndexWidth = 3;

   localparam logic [IdxWidth-1:0] HIGH_CLICK_LEN = 13'd1323;
   localparam logic [IdxWidth-1:0] LOW_CLICK_LEN  = 13'd882;
   localparam logic [IdxWidth-1:0] REST_CLICK_LEN = 13'd661;
   localparam logic [IdxWidth-1:0] MUTE_CLICK_LEN = 13'd44;

   localparam logic [CsrIndexWidth-1:0] REG_SAMPLES_PER_BEAT = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_BEATS_PER_BAR    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_FIRST_BEAT_SOUND = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_OTHER_BEAT_SOUND = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_REST_MODE        = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_SUBDIVISION_MODE = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_MUTE_MASK        = 3'd6;

   localparam logic [1:0] CODE_HIGH = 2'd0;
   localparam logic [1:0] CODE_LOW  = 2'd1;

   localparam logic [1:0] REST_SAME  = 2'd0;
   localparam logic [1:0] REST_SOUND = 2'd1;

   localparam logic [1:0] SID_SILENCE = 2'd0;
   localparam logic [1:0] SID_HIGH    = 2'd1;
   localparam logic [1:0] SID_LOW     = 2'd2;
   localparam logic [1:0] SID_REST    = 2'd3;

   localparam logic [3:0] SUB_HALF            = 4'd1;
   localparam logic [3:0] SUB_HALF_REST       = 4'd2;
   localparam logic [3:0] SUB_REST_HALF       = 4'd3;
   localparam logic [3:0] SUB_TRIPLET         = 4'd4;
   localparam logic [3:0] SUB_REST_TRIPLET    = 4'd5;
   localparam logic [3:0] SUB_TRIPLET_REST1   = 4'd6;
   localparam logic [3:0] SUB_TRIPLET_REST2   = 4'd7;
   localparam logic [3:0] SUB_TRIPLET_REST02  = 4'd8;
   localparam logic [3:0] SUB_QUARTER         = 4'd9;
   localparam logic [3:0] SUB_QUARTER_REST    = 4'd10;
   localparam logic [3:0] SUB_FIRST_QUARTER   = 4'd11;
   localparam logic [3:0] SUB_LAST_QUARTERS   = 4'd12;
   localparam logic [3:0] SUB_ODD_QUARTERS    = 4'd13;

   localparam int ResetSpb = 22050;
   localparam logic [SpbWidth-1:0] RESET_SPB        = SpbWidth'(ResetSpb);
   localparam logic [SpbWidth-1:0] RESET_HALF       = SpbWidth'(ResetSpb / 2);
   localparam logic [SpbWidth-1:0] RESET_THIRD      = SpbWidth'(ResetSpb / 3);
   localparam logic [SpbWidth-1:0] RESET_TWO_THIRD  = SpbWidth'(2 * (ResetSpb / 3));
   localparam logic [SpbWidth-1:0] RESET_QUARTER    = SpbWidth'(ResetSpb / 4);
   localparam logic [SpbWidth-1:0] RESET_TWO_QUART  = SpbWidth'(2 * (ResetSpb / 4));
   localparam logic [SpbWidth-1:0] RESET_THREE_QUART = SpbWidth'(3 * (ResetSpb / 4));
   localparam logic [BpbWidth-1:0] RESET_BPB        = 5'd4;
   localparam logic [1:0]          RESET_OTHER_SOUND = CODE_LOW;

   // ceil(2^23 / 3); exact floor(x / 3) for every x below 2^23.
   localparam int RecipShift = 23;
   localparam logic [SpbWidth-1:0] RECIP3 = SpbWidth'(((1 << RecipShift) + 2) / 3);

   // (num mod den) for den in 1..16 by five restoring steps.
   function automatic logic [3:0] mscs_wrap_beat(input logic [4:0] num,
                                                 input logic [4:0] den);
      logic [8:0] rem;
      logic [8:0] sub;
      rem = 9'(num);
      for (int k = 4; k >= 0; k--) begin
         sub = 9'(den) << k;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      return rem[3:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/metronome_subdivision_click_sequencer.sv */
// A result is registered and is valid in the cycle after its item is accepted.
// One item per cycle unless a stalled result is held; results drain as new items enter.
// The subdivision points are worked out when samples_per_beat is written.
// Reset is synchronous: counters, click state and result valid clear, and the
// configuration registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "metronome_subdivision_click_sequencer_assert.svh"

module metronome_subdivision_click_sequencer
   import mscs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic                     req_restart,
   input  wire logic                     req_playing,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [1:0]               rsp_sound_id,
   output      logic [IdxWidth-1:0]      rsp_sample_index,
   output      logic [3:0]               rsp_beat_index,
   output      logic                     rsp_click_start,
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [SpbWidth-1:0]      csr_wdata
);

   logic [SpbWidth-1:0] samples_per_beat_ff;
   logic [BpbWidth-1:0] beats_per_bar_ff;
   logic [1:0]          first_beat_sound_ff;
   logic [1:0]          other_beat_sound_ff;
   logic [1:0]          rest_mode_ff;
   logic [3:0]          subdivision_mode_ff;
   logic [15:0]         mute_mask_ff;
   logic [SpbWidth-1:0] half_ff;
   logic [SpbWidth-1:0] third_ff;
   logic [SpbWidth-1:0] two_third_ff;
   logic [SpbWidth-1:0] quarter_ff;
   logic [SpbWidth-1:0] two_quart_ff;
   logic [SpbWidth-1:0] three_quart_ff;

   logic [SpbWidth-1:0] beat_position_ff, beat_position_in;
   logic [3:0]          beat_counter_ff, beat_counter_in;
   logic [IdxWidth-1:0] click_index_ff, click_index_in;
   logic                click_active_ff, click_active_in;
   logic                click_is_rest_ff, click_is_rest_in;

   logic                rsp_valid_ff;
   logic [1:0]          sound_id_ff, sound_id_in;
   logic [IdxWidth-1:0] sample_index_ff, sample_index_in;
   logic [3:0]          beat_index_ff;
   logic                click_start_ff, click_start_in;

   logic                csr_fire;
   logic                req_fire;
   logic [43:0]         third_prod;
   logic [SpbWidth-1:0] wr_third;
   logic [SpbWidth-1:0] wr_quarter;

   logic [BpbWidth-1:0] bpb;
   logic                eq_h, eq_t, eq_2t, eq_q, eq_2q, eq_3q;
   logic                sub_hit;
   logic                sub_rest;
   logic                pos_zero;
   logic                begin_click;
   logic                audible;
   logic [1:0]          beat_code;
   logic [1:0]          cur_id;
   logic [IdxWidth-1:0] cur_len;
   logic                act_eff;
   logic                rest_eff;
   logic [IdxWidth-1:0] idx_eff;
   logic [SpbWidth-1:0] pos_inc;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign third_prod = 44'(csr_wdata) * 44'(RECIP3);
   assign wr_third   = SpbWidth'(third_prod[43:RecipShift]);
   assign wr_quarter = csr_wdata >> 2;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_per_beat_ff <= RESET_SPB;
         beats_per_bar_ff    <= RESET_BPB;
         first_beat_sound_ff <= CODE_HIGH;
         other_beat_sound_ff <= RESET_OTHER_SOUND;
         rest_mode_ff        <= REST_SAME;
         subdivision_mode_ff <= 4'd0;
         mute_mask_ff        <= 16'd0;
         half_ff             <= RESET_HALF;
         third_ff            <= RESET_THIRD;
         two_third_ff        <= RESET_TWO_THIRD;
         quarter_ff          <= RESET_QUARTER;
         two_quart_ff        <= RESET_TWO_QUART;
         three_quart_ff      <= RESET_THREE_QUART;
      end else if (csr_fire) begin
         case (csr_index)
            REG_SAMPLES_PER_BEAT: begin
               samples_per_beat_ff <= csr_wdata;
               half_ff             <= csr_wdata >> 1;
               third_ff            <= wr_third;
               two_third_ff        <= wr_third << 1;
               quarter_ff          <= wr_quarter;
               two_quart_ff        <= wr_quarter << 1;
               three_quart_ff      <= wr_quarter + (wr_quarter << 1);
            end
            REG_BEATS_PER_BAR:    beats_per_bar_ff    <= csr_wdata[BpbWidth-1:0];
            REG_FIRST_BEAT_SOUND: first_beat_sound_ff <= csr_wdata[1:0];
            REG_OTHER_BEAT_SOUND: other_beat_sound_ff <= csr_wdata[1:0];
            REG_REST_MODE:        rest_mode_ff        <= csr_wdata[1:0];
            REG_SUBDIVISION_MODE: subdivision_mode_ff <= csr_wdata[3:0];
            REG_MUTE_MASK:        mute_mask_ff        <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      bpb = beats_per_bar_ff;
      if (beats_per_bar_ff == 5'd0) begin
         bpb = 5'd1;
      end else if (beats_per_bar_ff > 5'd16) begin
         bpb = 5'd16;
      end

      eq_h  = beat_position_ff == half_ff;
      eq_t  = beat_position_ff == third_ff;
      eq_2t = beat_position_ff == two_third_ff;
      eq_q  = beat_position_ff == quarter_ff;
      eq_2q = beat_position_ff == two_quart_ff;
      eq_3q = beat_position_ff == three_quart_ff;

      sub_hit  = 1'b0;
      sub_rest = 1'b0;
      case (subdivision_mode_ff)
         SUB_HALF, SUB_REST_HALF: sub_hit = eq_h;
         SUB_HALF_REST: begin
            sub_hit  = eq_h;
            sub_rest = eq_h;
         end
         SUB_TRIPLET, SUB_REST_TRIPLET: sub_hit = eq_t || eq_2t;
         SUB_TRIPLET_REST1: begin
            sub_hit  = eq_t || eq_2t;
            sub_rest = eq_t;
         end
         SUB_TRIPLET_REST2, SUB_TRIPLET_REST02: begin
            sub_hit  = eq_t || eq_2t;
            sub_rest = eq_2t;
         end
         SUB_QUARTER: sub_hit = eq_q || eq_2q || eq_3q;
         SUB_QUARTER_REST: begin
            sub_hit  = eq_q || eq_2q || eq_3q;
            sub_rest = eq_2q;
         end
         SUB_FIRST_QUARTER: sub_hit = eq_q;
         SUB_LAST_QUARTERS: sub_hit = eq_2q || eq_3q;
         SUB_ODD_QUARTERS:  sub_hit = eq_q || eq_3q;
         default: begin
            sub_hit  = 1'b0;
            sub_rest = 1'b0;
         end
      endcase

      pos_zero    = beat_position_ff == '0;
      begin_click = pos_zero || sub_hit;
      audible     = (5'(beat_counter_ff) < bpb) && !mute_mask_ff[beat_counter_ff];

      act_eff  = click_active_ff;
      rest_eff = click_is_rest_ff;
      idx_eff  = click_index_ff;
      if (begin_click) begin
         act_eff  = 1'b1;
         rest_eff = sub_rest && !pos_zero;
         idx_eff  = '0;
      end

      beat_code = (beat_counter_ff == 4'd0) ? first_beat_sound_ff : other_beat_sound_ff;
      if (rest_eff && rest_mode_ff != REST_SAME) begin
         if (rest_mode_ff == REST_SOUND) begin
            cur_id  = SID_REST;
            cur_len = REST_CLICK_LEN;
         end else begin
            cur_id  = SID_SILENCE;
            cur_len = MUTE_CLICK_LEN;
         end
      end else if (beat_code == CODE_HIGH) begin
         cur_id  = SID_HIGH;
         cur_len = HIGH_CLICK_LEN;
      end else if (beat_code == CODE_LOW) begin
         cur_id  = SID_LOW;
         cur_len = LOW_CLICK_LEN;
      end else begin
         cur_id  = SID_SILENCE;
         cur_len = MUTE_CLICK_LEN;
      end

      pos_inc = beat_position_ff + SpbWidth'(1);

      beat_position_in = beat_position_ff;
      beat_counter_in  = beat_counter_ff;
      click_index_in   = click_index_ff;
      click_active_in  = click_active_ff;
      click_is_rest_in = click_is_rest_ff;
      sound_id_in      = SID_SILENCE;
      sample_index_in  = '0;
      click_start_in   = 1'b0;

      if (req_playing && req_restart) begin
         beat_position_in = '0;
         beat_counter_in  = '0;
         click_index_in   = '0;
         click_active_in  = 1'b0;
         click_is_rest_in = 1'b0;
      end else if (req_playing) begin
         if (audible) begin
            click_active_in  = act_eff;
            click_is_rest_in = rest_eff;
            click_index_in   = idx_eff;
            click_start_in   = begin_click;
            if (act_eff) begin
               if (idx_eff < cur_len) begin
                  sound_id_in     = cur_id;
                  sample_index_in = (cur_id != SID_SILENCE) ? idx_eff : '0;
                  click_index_in  = idx_eff + IdxWidth'(1);
               end else begin
                  click_active_in = 1'b0;
               end
            end
         end
         if (pos_inc >= samples_per_beat_ff) begin
            beat_position_in = '0;
            beat_counter_in  = mscs_wrap_beat(5'(beat_counter_ff) + 5'd1, bpb);
         end else begin
            beat_position_in = pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_position_ff <= '0;
         beat_counter_ff  <= '0;
         click_index_ff   <= '0;
         click_active_ff  <= 1'b0;
         click_is_rest_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_fire) begin
            beat_position_ff <= beat_position_in;
            beat_counter_ff  <= beat_counter_in;
            click_index_ff   <= click_index_in;
            click_active_ff  <= click_active_in;
            click_is_rest_ff <= click_is_rest_in;
            rsp_valid_ff     <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sound_id_ff     <= sound_id_in;
         sample_index_ff <= sample_index_in;
         beat_index_ff   <= beat_counter_ff;
         click_start_ff  <= click_start_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sound_id     = sound_id_ff;
   assign rsp_sample_index = sample_index_ff;
   assign rsp_beat_index   = beat_index_ff;
   assign rsp_click_start  = click_start_ff;

   `MSCS_ASSERT_SAME(a_silence_index_zero, rsp_valid && rsp_sound_id == SID_SILENCE, rsp_sample_index == '0, "silent item carries a nonzero sample index")

   `MSCS_ASSERT_SAME(a_start_index_zero, rsp_valid && rsp_click_start, rsp_sample_index == '0, "click start does not begin at sample zero")

   `MSCS_ASSERT_NEXT(a_hold_when_stopped, req_fire && !req_playing, $stable(beat_position_ff) && $stable(beat_counter_ff) && $stable(click_index_ff), "counters moved while not playing")

   `MSCS_ASSERT_NEXT(a_restart_clears, req_fire && req_playing && req_restart, beat_position_ff == '0 && beat_counter_ff == '0 && !click_active_ff, "restart left state behind")

endmodule

`default_nettype wire
